// ===== sv/cfa_pkg.sv =====
// Shared types and constants of the contiguous frame allocator.
// No dependencies; used by cfa_seq, the top level and the testbench.
`default_nettype none

package cfa_pkg;

  // Field widths
  localparam int FRAME_W   = 20;
  localparam int CNT_W     = 13;
  localparam int POOL_W    = 13;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 3;
  localparam int FS_W      = 2;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  // Store depth default
  localparam int DEF_MAX_FRAMES = 4096;

  // Reset values of the configuration registers
  localparam logic [FRAME_W-1:0] BASE_RST = '0;
  localparam logic [POOL_W-1:0]  POOL_RST = 13'd4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd1;

  // Request types
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK    = 2'd2;

  // Per-frame state codes
  localparam logic [FS_W-1:0] FS_FREE = 2'b00;
  localparam logic [FS_W-1:0] FS_USED = 2'b01;
  localparam logic [FS_W-1:0] FS_HEAD = 2'b10;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_COUNT = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_RUN    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_HEAD  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [FRAME_W-1:0] base_frame;
    logic [POOL_W-1:0]  pool_frames;
  } cfa_cfg_t;

  // One result item
  typedef struct packed {
    logic [FRAME_W-1:0] result_frame;
    logic [STAT_W-1:0]  status;
  } cfa_res_t;

endpackage

`default_nettype wire

// ===== sv/cfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/cfa_seq.sv =====
// Request sequencer: checks, scans, fills and frees the frame state store.
// Depends on cfa_pkg and cfa_ram.
`default_nettype none

module cfa_seq #(
  parameter int MAX_FRAMES = cfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cfa_pkg::cfa_cfg_t            cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cfa_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [cfa_pkg::CNT_W-1:0]    in_count,
  input  wire logic [cfa_pkg::FRAME_W-1:0]  in_frame_no,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output cfa_pkg::cfa_res_t                 res
);

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int AW1   = IDX_W + 1;
  localparam int SZ_W  = (cfa_pkg::CNT_W > AW1) ? cfa_pkg::CNT_W : AW1;
  localparam int CMP_W = cfa_pkg::FRAME_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAMES - 1);
  localparam logic [SZ_W-1:0]  MAX_SZ   = SZ_W'(MAX_FRAMES);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_OFFS  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_FILL  = 7'b0100000,
    S_FREE  = 7'b1000000
  } state_t;

  // Result hand-off is a flag beside the state machine
  state_t                         state_r, state_nxt;
  logic                           done_r, done_nxt;
  logic [cfa_pkg::REQ_W-1:0]      req_r, req_nxt;
  logic [cfa_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [cfa_pkg::FRAME_W-1:0]    frame_r, frame_nxt;
  logic [cfa_pkg::FRAME_W-1:0]    offs_r, offs_nxt;
  logic                           below_r, below_nxt;
  logic [AW1-1:0]                 addr_r, addr_nxt;
  logic [IDX_W-1:0]               dix_r, dix_nxt;
  logic                           pend_r, pend_nxt;
  logic [cfa_pkg::CNT_W-1:0]      run_r, run_nxt;
  logic [AW1-1:0]                 rs_r, rs_nxt;
  logic [IDX_W-1:0]               wp_r, wp_nxt;
  logic [IDX_W-1:0]               start_r, start_nxt;
  logic [AW1-1:0]                 endx_r, endx_nxt;
  logic                           first_r, first_nxt;
  logic [cfa_pkg::STAT_W-1:0]     status_r, status_nxt;
  logic [cfa_pkg::FRAME_W-1:0]    result_r, result_nxt;

  logic [SZ_W-1:0]                pool_n;
  logic [CMP_W-1:0]               n_c, count_c, offs_c, sum_c;
  logic                           addr_lt_n;
  logic [cfa_pkg::CNT_W:0]        run_inc;
  logic                           we;
  logic [IDX_W-1:0]               waddr, raddr;
  logic [cfa_pkg::FS_W-1:0]       wdata, rdata;

  // Effective pool size: the smaller of the register and the store depth
  always_comb begin
    if (SZ_W'(cfg.pool_frames) < MAX_SZ) begin
      pool_n = SZ_W'(cfg.pool_frames);
    end else begin
      pool_n = MAX_SZ;
    end
  end

  assign n_c       = CMP_W'(pool_n);
  assign count_c   = CMP_W'(count_r);
  assign offs_c    = CMP_W'(offs_r);
  assign sum_c     = offs_c + count_c;
  assign addr_lt_n = SZ_W'(addr_r) < pool_n;
  assign run_inc   = {1'b0, run_r} + (cfa_pkg::CNT_W + 1)'(1);

  cfa_ram #(
    .WIDTH (cfa_pkg::FS_W),
    .DEPTH (MAX_FRAMES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    done_nxt   = done_r;
    req_nxt    = req_r;
    count_nxt  = count_r;
    frame_nxt  = frame_r;
    offs_nxt   = offs_r;
    below_nxt  = below_r;
    addr_nxt   = addr_r;
    dix_nxt    = dix_r;
    pend_nxt   = pend_r;
    run_nxt    = run_r;
    rs_nxt     = rs_r;
    wp_nxt     = wp_r;
    start_nxt  = start_r;
    endx_nxt   = endx_r;
    first_nxt  = first_r;
    status_nxt = status_r;
    result_nxt = result_r;
    we         = 1'b0;
    waddr      = wp_r;
    wdata      = cfa_pkg::FS_FREE;
    raddr      = addr_r[IDX_W-1:0];
    in_ready   = 1'b0;

    case (state_r)
      // Clearing pass over the whole store after reset
      S_CLEAR: begin
        we     = 1'b1;
        wp_nxt = wp_r + IDX_W'(1);
        if (wp_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a new item once the previous result has been handed off
      S_IDLE: begin
        in_ready = !done_r;
        if (in_valid && !done_r) begin
          req_nxt    = in_req_type;
          count_nxt  = in_count;
          frame_nxt  = in_frame_no;
          result_nxt = '0;
          state_nxt  = S_OFFS;
        end
      end

      // Pool-relative offset of frame_no
      S_OFFS: begin
        offs_nxt  = frame_r - cfg.base_frame;
        below_nxt = frame_r < cfg.base_frame;
        state_nxt = S_CHECK;
      end

      // Argument checks and dispatch
      S_CHECK: begin
        case (req_r)
          cfa_pkg::REQ_ALLOC: begin
            if (count_c == '0 || count_c > n_c) begin
              status_nxt = cfa_pkg::ST_BAD_COUNT;
              done_nxt   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              addr_nxt  = '0;
              run_nxt   = '0;
              rs_nxt    = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          cfa_pkg::REQ_RELEASE: begin
            if (below_r || offs_c >= n_c) begin
              status_nxt = cfa_pkg::ST_RANGE;
              done_nxt   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              addr_nxt  = offs_r[AW1-1:0];
              first_nxt = 1'b1;
              pend_nxt  = 1'b0;
              state_nxt = S_FREE;
            end
          end
          cfa_pkg::REQ_MARK: begin
            if (count_c == '0 || count_c > n_c) begin
              status_nxt = cfa_pkg::ST_BAD_COUNT;
              done_nxt   = 1'b1;
              state_nxt  = S_IDLE;
            end else if (below_r || sum_c > n_c) begin
              status_nxt = cfa_pkg::ST_RANGE;
              done_nxt   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              wp_nxt     = offs_r[IDX_W-1:0];
              start_nxt  = offs_r[IDX_W-1:0];
              endx_nxt   = sum_c[AW1-1:0];
              status_nxt = cfa_pkg::ST_OK;
              state_nxt  = S_FILL;
            end
          end
          default: begin
            status_nxt = cfa_pkg::ST_BAD_COUNT;
            done_nxt   = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end

      // First-fit scan, one frame per cycle, each read issued in the cycle before its data is checked
      S_SCAN: begin
        if (addr_lt_n) begin
          addr_nxt = addr_r + AW1'(1);
          dix_nxt  = addr_r[IDX_W-1:0];
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (rdata == cfa_pkg::FS_FREE) begin
            run_nxt = run_inc[cfa_pkg::CNT_W-1:0];
            if (run_inc == {1'b0, count_r}) begin
              start_nxt  = rs_r[IDX_W-1:0];
              wp_nxt     = rs_r[IDX_W-1:0];
              endx_nxt   = AW1'(dix_r) + AW1'(1);
              result_nxt = cfg.base_frame + cfa_pkg::FRAME_W'(rs_r);
              status_nxt = cfa_pkg::ST_OK;
              state_nxt  = S_FILL;
            end
          end else begin
            run_nxt = '0;
            rs_nxt  = AW1'(dix_r) + AW1'(1);
          end
        end else if (!addr_lt_n) begin
          status_nxt = cfa_pkg::ST_NO_RUN;
          done_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      // Write head then used frames up to the exclusive end
      S_FILL: begin
        we     = 1'b1;
        waddr  = wp_r;
        wdata  = (wp_r == start_r) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
        wp_nxt = wp_r + IDX_W'(1);
        if (AW1'(wp_r) + AW1'(1) == endx_r) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // Release walk: head check, then free used frames that follow
      S_FREE: begin
        if (addr_lt_n) begin
          addr_nxt = addr_r + AW1'(1);
          dix_nxt  = addr_r[IDX_W-1:0];
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        waddr = dix_r;
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            if (rdata != cfa_pkg::FS_HEAD) begin
              status_nxt = cfa_pkg::ST_NOT_HEAD;
              done_nxt   = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              we = 1'b1;
            end
          end else if (rdata == cfa_pkg::FS_USED) begin
            we = 1'b1;
          end else begin
            status_nxt = cfa_pkg::ST_OK;
            done_nxt   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (!addr_lt_n) begin
          status_nxt = cfa_pkg::ST_OK;
          done_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Result hand-off to the output register
    if (done_r && res_ready) begin
      done_nxt = 1'b0;
    end
  end

  assign res_valid        = done_r;
  assign res.result_frame = result_r;
  assign res.status       = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      done_r  <= 1'b0;
      wp_r    <= '0;
      pend_r  <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      wp_r    <= wp_nxt;
      pend_r  <= pend_nxt;
      first_r <= first_nxt;
    end
    req_r    <= req_nxt;
    count_r  <= count_nxt;
    frame_r  <= frame_nxt;
    offs_r   <= offs_nxt;
    below_r  <= below_nxt;
    addr_r   <= addr_nxt;
    dix_r    <= dix_nxt;
    run_r    <= run_nxt;
    rs_r     <= rs_nxt;
    start_r  <= start_nxt;
    endx_r   <= endx_nxt;
    status_r <= status_nxt;
    result_r <= result_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/contiguous_frame_allocator_top.sv =====
// Top level of the contiguous frame allocator: configuration registers,
// output register and the request sequencer. Depends on cfa_pkg, cfa_seq.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    req_type, count, frame_no
//   out_     output     out_valid/out_ready  result_frame, status
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// After reset a clearing pass writes every store entry to free, with
// in_ready low. An item then passes the offset and check states, then:
// allocate scans the pool for a free run (one store read per cycle) and
// fills it, mark fills its run, release walks the run from its head.
// The sequencer has a single store read port. A waiting result sits in the
// output register and the next item is taken meanwhile.
`default_nettype none

module contiguous_frame_allocator_top #(
  parameter int MAX_FRAMES = cfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [cfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cfa_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [cfa_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [cfa_pkg::CNT_W-1:0]       in_count,
  input  wire logic [cfa_pkg::FRAME_W-1:0]     in_frame_no,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [cfa_pkg::FRAME_W-1:0]          out_result_frame,
  output logic [cfa_pkg::STAT_W-1:0]           out_status
);

  cfa_pkg::cfa_cfg_t cfg_r;
  cfa_pkg::cfa_res_t res, res_r;
  logic              res_valid, res_ready;
  logic              out_valid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_frame  <= cfa_pkg::BASE_RST;
      cfg_r.pool_frames <= cfa_pkg::POOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cfa_pkg::CFG_BASE: cfg_r.base_frame  <= cfg_wdata[cfa_pkg::FRAME_W-1:0];
        cfa_pkg::CFG_POOL: cfg_r.pool_frames <= cfg_wdata[cfa_pkg::POOL_W-1:0];
        default: ;
      endcase
    end
  end

  cfa_seq #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_count    (in_count),
    .in_frame_no (in_frame_no),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_frame = res_r.result_frame;
  assign out_status       = res_r.status;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for contiguous_frame_allocator_top: allocate, release
// and mark requests, plus unknown codes, against a behavioral frame map, under random idling.
// Depends on cfa_pkg and contiguous_frame_allocator_top.
`timescale 1ns / 1ps

module tb;
  import cfa_pkg::*;

  localparam int MAX_FRAMES    = DEF_MAX_FRAMES;
  localparam int MAX_GAP       = 8;
  localparam int MAX_STALL     = 32;
  localparam int SETTLE_CYCLES = 16;

  // Codes the package does not name
  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type = REQ_ALLOC;
  logic [CNT_W-1:0]     in_count = '0;
  logic [FRAME_W-1:0]   in_frame_no = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FRAME_W-1:0]   out_result_frame;
  logic [STAT_W-1:0]    out_status;

  // Behavioral copy of the allocator state and its registers
  logic [FS_W-1:0]    frame_map [MAX_FRAMES];
  logic [FRAME_W-1:0] base_reg = BASE_RST;
  logic [POOL_W-1:0]  pool_cfg = POOL_RST;

  cfa_res_t pending_results [$];
  int       mismatches = 0;
  int       results_checked = 0;
  int       req_tally [4] = '{default: 0};
  int       status_tally [8] = '{default: 0};
  int       burst_left = 0;
  longint   cycle_count = 0;
  longint   cycle_budget = 0;

  logic [15:0] ready_pat = 16'hFFFF;
  int          ready_pos = 0;

  contiguous_frame_allocator_top #(
    .MAX_FRAMES(MAX_FRAMES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_count         (in_count),
    .in_frame_no      (in_frame_no),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_frame (out_result_frame),
    .out_status       (out_status)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frames the pool actually manages
  function automatic int managed_frames();
    return (pool_cfg < MAX_FRAMES) ? int'(pool_cfg) : MAX_FRAMES;
  endfunction

  // Apply one request to the frame map and return the result it should give
  function automatic cfa_res_t predict_request(logic [REQ_W-1:0] req,
                                               logic [CNT_W-1:0] cnt,
                                               logic [FRAME_W-1:0] fno);
    cfa_res_t r;
    int n, c, run, start, offs, i, k;
    bit found;
    r.result_frame = '0;
    r.status = ST_BAD_COUNT;
    n = managed_frames();
    c = int'(cnt);
    offs = int'(fno) - int'(base_reg);
    case (req)
      REQ_ALLOC: begin
        if (c != 0 && c <= n) begin
          r.status = ST_NO_RUN;
          run = 0;
          found = 1'b0;
          for (i = 0; i < n && !found; i++) begin
            run = (frame_map[i] == FS_FREE) ? run + 1 : 0;
            if (run == c) begin
              start = i + 1 - c;
              frame_map[start] = FS_HEAD;
              for (k = start + 1; k <= i; k++) frame_map[k] = FS_USED;
              r.result_frame = base_reg + FRAME_W'(start);
              r.status = ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (offs < 0 || offs >= n) begin
          r.status = ST_RANGE;
        end else if (frame_map[offs] != FS_HEAD) begin
          r.status = ST_NOT_HEAD;
        end else begin
          // free the head, then walk the used frames behind it
          frame_map[offs] = FS_FREE;
          for (k = offs + 1; k < n && frame_map[k] == FS_USED; k++) frame_map[k] = FS_FREE;
          r.status = ST_OK;
        end
      end
      REQ_MARK: begin
        if (c == 0 || c > n) begin
          r.status = ST_BAD_COUNT;
        end else if (offs < 0 || offs + c > n) begin
          r.status = ST_RANGE;
        end else begin
          frame_map[offs] = FS_HEAD;
          for (k = offs + 1; k < offs + c; k++) frame_map[k] = FS_USED;
          r.status = ST_OK;
        end
      end
      default: r.status = ST_BAD_COUNT;
    endcase
    return r;
  endfunction

  // Send one item, with a random gap between bursts
  task automatic send_item(logic [REQ_W-1:0] req, logic [CNT_W-1:0] cnt,
                           logic [FRAME_W-1:0] fno);
    int gap;
    cfa_res_t want;
    if (burst_left == 0) begin
      gap = $urandom_range(0, MAX_GAP);
      burst_left = ($urandom_range(3) == 0) ? 24 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_count    <= cnt;
    in_frame_no <= fno;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_request(req, cnt, fno);
    pending_results.push_back(want);
    req_tally[req]++;
    status_tally[want.status]++;
    // worst case: full scan plus fill, longest stall and gap
    cycle_budget += 2 * managed_frames() + 8 + MAX_GAP + MAX_STALL;
  endtask

  // Hold the sender until every result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cycle_budget += SETTLE_CYCLES;
  endtask

  // Register writes, only with the block idle
  task automatic configure(logic [CFG_W-1:0] base_word, logic [CFG_W-1:0] pool_word,
                           bit spare);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base_word;
    @(posedge clk);
    cfg_index <= CFG_POOL;
    cfg_wdata <= pool_word;
    @(posedge clk);
    if (spare) begin
      // unassigned index: must leave both registers alone
      cfg_index <= CFG_SPARE;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    base_reg = base_word;
    pool_cfg = pool_word[POOL_W-1:0];
    cycle_budget += 4;
  endtask

  // Reset values: full 4096-frame pool at base 0
  task automatic test_reset_pool();
    send_item(REQ_ALLOC, 13'd4096, '0);
    send_item(REQ_ALLOC, 13'd1, '0);
    send_item(REQ_RELEASE, '0, 20'd5);
    send_item(REQ_RELEASE, '0, 20'd0);
    send_item(REQ_ALLOC, 13'd0, '0);
    send_item(REQ_ALLOC, 13'h1FFF, '0);
    send_item(REQ_MARK, 13'd0, 20'd0);
    send_item(REQ_MARK, 13'd1, 20'd4095);
    send_item(REQ_MARK, 13'd2, 20'd4095);
    send_item(REQ_RELEASE, '0, 20'hFFFFF);
    send_item(REQ_UNKNOWN, 13'h1FFF, 20'hFFFFF);
    send_item(REQ_RELEASE, '0, 20'd4095);
  endtask

  // Base near the top of the frame space: result wraps, low frames fall outside
  task automatic test_wrapped_base();
    configure(20'hFFFF8, 20'hFE010, 1'b0);
    send_item(REQ_ALLOC, 13'd4, '0);
    send_item(REQ_ALLOC, 13'd8, '0);
    send_item(REQ_ALLOC, 13'd4, '0);
    send_item(REQ_ALLOC, 13'd1, '0);
    send_item(REQ_RELEASE, '0, 20'h00004);
    send_item(REQ_RELEASE, '0, 20'hFFFF9);
    send_item(REQ_RELEASE, '0, 20'hFFFFC);
    send_item(REQ_MARK, 13'd16, 20'hFFFF8);
    send_item(REQ_MARK, 13'd10, 20'hFFFFF);
    send_item(REQ_RELEASE, '0, 20'hFFFF8);
  endtask

  // Empty pool, then a pool size beyond the store depth
  task automatic test_pool_limits();
    configure(20'd0, 20'd0, 1'b1);
    send_item(REQ_ALLOC, 13'd1, '0);
    send_item(REQ_RELEASE, '0, 20'd0);
    send_item(REQ_MARK, 13'd1, 20'd0);
    configure(20'h7FFFF, 20'h01FFF, 1'b0);
    send_item(REQ_ALLOC, 13'd3, '0);
    send_item(REQ_RELEASE, '0, 20'h80FFF);
    send_item(REQ_MARK, 13'd3, 20'h80FFC);
    send_item(REQ_RELEASE, '0, 20'h80FFC);
    send_item(REQ_RELEASE, '0, 20'h7FFFF);
  endtask

  // Mostly well-formed traffic: releases aim at live heads, marks stay in range
  task automatic run_random(int items);
    int n, span, sel, off, i, j;
    int heads [$];
    logic [REQ_W-1:0] req;
    logic [CNT_W-1:0] cnt;
    logic [FRAME_W-1:0] fno;
    for (j = 0; j < items; j++) begin
      n = managed_frames();
      span = (n > 1) ? n : 1;
      sel = $urandom_range(99);
      cnt = CNT_W'($urandom);
      fno = FRAME_W'($urandom);
      off = $urandom_range(span - 1);
      if (sel < 45) begin
        req = REQ_ALLOC;
        if ($urandom_range(9) != 0)
          cnt = CNT_W'($urandom_range(1, (span < 128) ? span / 4 + 1 : 32));
      end else if (sel < 80) begin
        req = REQ_RELEASE;
        heads.delete();
        for (i = 0; i < n; i++) if (frame_map[i] == FS_HEAD) heads.push_back(i);
        if (heads.size() != 0 && $urandom_range(3) != 0)
          fno = base_reg + FRAME_W'(heads[$urandom_range(heads.size() - 1)]);
        else if ($urandom_range(1) == 0)
          fno = base_reg + FRAME_W'(off);
      end else if (sel < 95) begin
        req = REQ_MARK;
        if ($urandom_range(7) != 0) begin
          fno = base_reg + FRAME_W'(off);
          cnt = CNT_W'($urandom_range(1, (span - off) / 4 + 1));
        end
      end else begin
        req = REQ_UNKNOWN;
      end
      send_item(req, cnt, fno);
      if ($urandom_range(24) == 0) drain();
    end
  endtask

  task automatic test_random_traffic();
    configure(CFG_W'($urandom), CFG_W'($urandom_range(8, 64)), 1'b0);
    run_random(30);
    configure(20'hFFFFF - CFG_W'($urandom_range(0, 40)),
              {7'($urandom), 13'd32}, 1'b0);
    run_random(20);
    configure(20'd0, CFG_W'($urandom_range(1, 8)), 1'b0);
    run_random(20);
    configure(CFG_W'($urandom), 20'd4096, 1'b0);
    run_random(20);
    configure(20'hFFFFF, 20'd128, 1'b1);
    run_random(20);
  endtask

  // Receiver back-pressure: a 16-bit ready pattern, reloaded when it runs out
  always @(posedge clk) begin
    out_ready <= ready_pat[ready_pos];
    if (ready_pos == 15) begin
      ready_pos = 0;
      ready_pat = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      ready_pos++;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    cfa_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: frame %h status %0d",
                 $time, out_result_frame, out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_frame !== want.result_frame) begin
          $display("%0t: result_frame expected %h, got %h",
                   $time, want.result_frame, out_result_frame);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: several times the worst-case time of the work issued so far,
  // plus the clearing pass after reset
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * (MAX_FRAMES + cycle_budget) + 2000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_FRAMES; i++) frame_map[i] = FS_FREE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_pool();
    test_wrapped_base();
    test_pool_limits();
    test_random_traffic();
    drain();
    $display("tb: %0d requests (alloc %0d, release %0d, mark %0d, unknown %0d), %0d checked",
             req_tally[0] + req_tally[1] + req_tally[2] + req_tally[3], req_tally[REQ_ALLOC],
             req_tally[REQ_RELEASE], req_tally[REQ_MARK], req_tally[REQ_UNKNOWN],
             results_checked);
    $display("tb: outcomes ok %0d, bad count %0d, no run %0d, not head %0d, range %0d",
             status_tally[ST_OK], status_tally[ST_BAD_COUNT], status_tally[ST_NO_RUN],
             status_tally[ST_NOT_HEAD], status_tally[ST_RANGE]);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
